@@ hw/rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg - shared types and helpers of the source text lexer
// Token kinds, error codes, result record layout, character classes and
// the keyword table.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS         = 3;

   // token kinds
   localparam logic [4:0] KIND_ADD   = 5'd0;
   localparam logic [4:0] KIND_SUB   = 5'd1;
   localparam logic [4:0] KIND_NEG   = 5'd7;
   localparam logic [4:0] KIND_INT   = 5'd8;
   localparam logic [4:0] KIND_FLT   = 5'd9;
   localparam logic [4:0] KIND_IDENT = 5'd10;
   localparam logic [4:0] KIND_KW0   = 5'd11;
   localparam logic [4:0] KIND_BOOL  = 5'd17;
   localparam logic [4:0] KIND_FALSE = 5'd20;
   localparam logic [4:0] KIND_END   = 5'd24;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_POINT = 2'd1;
   localparam logic [1:0] ERR_CHAR  = 2'd2;

   // characters
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // keywords, written back to front so the first character lands in the low byte
   localparam int KW_COUNT = 13;
   localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
      40'("23i"), 40'("46i"), 40'("23u"), 40'("46u"), 40'("23f"), 40'("46f"),
      40'("loob"), 40'("rahc"), 40'("eurt"), 40'("eslaf"), 40'("rav"),
      40'("tsnoc"), 40'("war")
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd3, 3'd5, 3'd3
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [1:0]  err;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic [1:0]    count;
      rec_type [2:0] rec;
   } entry_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {CHAR_SPACE, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_value(input logic [4:0] k);
      return k inside {KIND_INT, KIND_FLT, KIND_IDENT, [KIND_BOOL:KIND_FALSE]};
   endfunction

   // bit 3 set when c is one of the seven punctuators, kind in the low bits
   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         CHAR_PLUS:  r = 4'b1000;
         CHAR_MINUS: r = 4'b1001;
         CHAR_STAR:  r = 4'b1010;
         CHAR_SLASH: r = 4'b1011;
         CHAR_EQUAL: r = 4'b1100;
         CHAR_SEMI:  r = 4'b1101;
         CHAR_COLON: r = 4'b1110;
         default:    r = 4'b0000;
      endcase
      return r;
   endfunction

   // len is the word length clipped to seven for anything above five
   function automatic logic [4:0] word_kind(input logic [39:0] prefix, input logic [2:0] len);
      logic [4:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            k = KIND_KW0 + 5'(i);
         end
      end
      return k;
   endfunction

   function automatic rec_type mk_rec(input logic [4:0] kind, input logic [31:0] start,
                                      input logic [31:0] len, input logic [1:0] err,
                                      input logic last);
      rec_type r;
      r.kind   = kind;
      r.start  = start[15:0];
      r.length = (|len[31:16]) ? 16'hFFFF : len[15:0];
      r.err    = err;
      r.last   = last;
      return r;
   endfunction

endpackage

@@ hw/rtl/stl_front.sv @@
// ----------------------------------------------------------------------------
// stl_front - byte scanner
// Classifies each byte, keeps the scan state and builds the up to three
// result records that the byte causes, as one queue entry.
// ----------------------------------------------------------------------------
module stl_front #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output logic                push,
   output stl_pkg::entry_type  push_entry
);

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_MINUS  = 5'b00010,
      MODE_NUMBER = 5'b00100,
      MODE_WORD   = 5'b01000,
      MODE_ERROR  = 5'b10000
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic                   seen_ff, seen_in;
   logic [4:0]             prev_ff, prev_in;
   logic [39:0]            prefix_ff, prefix_in;

   stl_pkg::rec_type [2:0] res;
   logic [1:0]             cnt;
   logic [OFFSET_BITS-1:0] len1, len2;
   logic [2:0]             len_clip;
   logic [3:0]             pk;
   logic                   ends;

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      seen_in   = seen_ff;
      prev_in   = prev_ff;
      prefix_in = prefix_ff;
      res       = '0;
      cnt       = 2'd0;
      len2      = '0;
      len_clip  = 3'd0;
      ends      = (text_byte == 8'd0) || end_of_text;
      len1      = pos_ff - begin_ff;
      pk        = stl_pkg::punct_kind(text_byte);

      if (mode_ff == MODE_ERROR) begin
         if (ends) begin
            mode_in = MODE_IDLE;
         end
      end else begin
         if (text_byte != 8'd0) begin
            if (mode_ff == MODE_MINUS && stl_pkg::is_digit(text_byte)) begin
               mode_in = MODE_NUMBER;
               seen_in = 1'b0;
            end else if (mode_ff == MODE_NUMBER && stl_pkg::is_digit(text_byte)) begin
               mode_in = MODE_NUMBER;
            end else if (mode_ff == MODE_NUMBER && text_byte == stl_pkg::CHAR_POINT) begin
               if (seen_ff) begin
                  res[cnt] = stl_pkg::mk_rec(stl_pkg::KIND_ADD, 32'(begin_ff), 32'd0,
                                             stl_pkg::ERR_POINT, 1'b1);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_ERROR;
               end else begin
                  seen_in = 1'b1;
               end
            end else if (mode_ff == MODE_WORD &&
                         (stl_pkg::is_alpha(text_byte) || stl_pkg::is_digit(text_byte) ||
                          text_byte == stl_pkg::CHAR_UNDER)) begin
               if (len1 < OFFSET_BITS'(5)) begin
                  prefix_in = prefix_ff | (40'(text_byte) << {len1[2:0], 3'b000});
               end
            end else begin
               // close the open token at this byte
               case (mode_ff)
                  MODE_MINUS: begin
                     res[cnt] = stl_pkg::mk_rec(stl_pkg::KIND_NEG, 32'(begin_ff), 32'd1,
                                                stl_pkg::ERR_NONE, 1'b0);
                     prev_in  = stl_pkg::KIND_NEG;
                     cnt      = cnt + 2'd1;
                  end
                  MODE_NUMBER: begin
                     prev_in  = seen_ff ? stl_pkg::KIND_FLT : stl_pkg::KIND_INT;
                     res[cnt] = stl_pkg::mk_rec(prev_in, 32'(begin_ff), 32'(len1),
                                                stl_pkg::ERR_NONE, 1'b0);
                     cnt      = cnt + 2'd1;
                  end
                  MODE_WORD: begin
                     len_clip = (len1 > OFFSET_BITS'(5)) ? 3'd7 : len1[2:0];
                     prev_in  = stl_pkg::word_kind(prefix_ff, len_clip);
                     res[cnt] = stl_pkg::mk_rec(prev_in, 32'(begin_ff), 32'(len1),
                                                stl_pkg::ERR_NONE, 1'b0);
                     cnt      = cnt + 2'd1;
                  end
                  default: begin
                  end
               endcase
               mode_in = MODE_IDLE;

               if (stl_pkg::is_space(text_byte)) begin
                  mode_in = MODE_IDLE;
               end else if (text_byte == stl_pkg::CHAR_MINUS && !stl_pkg::is_value(prev_in)) begin
                  mode_in  = MODE_MINUS;
                  begin_in = pos_ff;
               end else if (pk[3]) begin
                  res[cnt] = stl_pkg::mk_rec({2'b00, pk[2:0]}, 32'(pos_ff), 32'd1,
                                             stl_pkg::ERR_NONE, 1'b0);
                  prev_in  = {2'b00, pk[2:0]};
                  cnt      = cnt + 2'd1;
               end else if (stl_pkg::is_digit(text_byte)) begin
                  mode_in  = MODE_NUMBER;
                  begin_in = pos_ff;
                  seen_in  = 1'b0;
               end else if (stl_pkg::is_alpha(text_byte) || text_byte == stl_pkg::CHAR_UNDER) begin
                  mode_in   = MODE_WORD;
                  begin_in  = pos_ff;
                  prefix_in = 40'(text_byte);
               end else begin
                  res[cnt] = stl_pkg::mk_rec(stl_pkg::KIND_ADD, 32'(pos_ff), 32'd0,
                                             stl_pkg::ERR_CHAR, 1'b1);
                  cnt      = cnt + 2'd1;
                  mode_in  = MODE_ERROR;
               end
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
         end

         if (mode_in != MODE_ERROR && ends) begin
            // text ends: close whatever is open, then the end token
            len2 = pos_in - begin_in;
            case (mode_in)
               MODE_MINUS: begin
                  res[cnt] = stl_pkg::mk_rec(stl_pkg::KIND_NEG, 32'(begin_in), 32'd1,
                                             stl_pkg::ERR_NONE, 1'b0);
                  cnt      = cnt + 2'd1;
               end
               MODE_NUMBER: begin
                  res[cnt] = stl_pkg::mk_rec(seen_in ? stl_pkg::KIND_FLT : stl_pkg::KIND_INT,
                                             32'(begin_in), 32'(len2), stl_pkg::ERR_NONE, 1'b0);
                  cnt      = cnt + 2'd1;
               end
               MODE_WORD: begin
                  len_clip = (len2 > OFFSET_BITS'(5)) ? 3'd7 : len2[2:0];
                  res[cnt] = stl_pkg::mk_rec(stl_pkg::word_kind(prefix_in, len_clip),
                                             32'(begin_in), 32'(len2), stl_pkg::ERR_NONE, 1'b0);
                  cnt      = cnt + 2'd1;
               end
               default: begin
               end
            endcase
            res[cnt] = stl_pkg::mk_rec(stl_pkg::KIND_END, 32'(pos_in), 32'd0,
                                       stl_pkg::ERR_NONE, 1'b1);
            cnt      = cnt + 2'd1;
         end

         if (ends) begin
            mode_in = MODE_IDLE;
         end
      end

      // back to the reset state for the next text
      if (ends && mode_in == MODE_IDLE) begin
         pos_in    = '0;
         begin_in  = '0;
         seen_in   = 1'b0;
         prev_in   = stl_pkg::KIND_END;
         prefix_in = '0;
      end
   end

   assign push             = take && (cnt != 2'd0);
   assign push_entry.count = cnt;
   assign push_entry.rec   = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         begin_ff  <= '0;
         seen_ff   <= 1'b0;
         prev_ff   <= stl_pkg::KIND_END;
         prefix_ff <= '0;
      end else if (take) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         seen_ff   <= seen_in;
         prev_ff   <= prev_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

@@ hw/rtl/stl_queue.sv @@
// ----------------------------------------------------------------------------
// stl_queue - entry queue between scanner and result stage
// Small first-in first-out store of per-byte result groups.
// ----------------------------------------------------------------------------
module stl_queue #(
   parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stl_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output stl_pkg::entry_type head_entry
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   stl_pkg::entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ff, wr_in;
   logic [PTR_BITS-1:0]    rd_ff, rd_in;
   logic [CNT_BITS-1:0]    fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign full       = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/stl_back.sv @@
// ----------------------------------------------------------------------------
// stl_back - result stage
// Walks the records of the head queue entry and hands them out one beat
// at a time through the output register.
// ----------------------------------------------------------------------------
module stl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  stl_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,
   output logic [6:0]         rsp_tuser,
   output logic               rsp_tlast
);

   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   stl_pkg::rec_type rec_ff;
   logic             load;
   logic             last_of_entry;

   assign load          = head_valid && (!valid_ff || rsp_tready);
   assign last_of_entry = (idx_ff == head_entry.count - 2'd1);
   assign pop           = load && last_of_entry;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_of_entry ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= head_entry.rec[idx_ff];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {rec_ff.length, rec_ff.start};
   assign rsp_tuser  = {rec_ff.err, rec_ff.kind};
   assign rsp_tlast  = rec_ff.last;

endmodule

@@ hw/rtl/source_text_lexer_core.sv @@
// ----------------------------------------------------------------------------
// source_text_lexer_core - streaming lexer for a small source language
// Bytes in, tokens out with kind, start offset, length and error code.
//
//   channel  dir  beat content
//   req_     in   one text byte, tlast on the final byte of the text
//   rsp_     out  one token or error, tlast on the end token or an error
//
// A byte is taken every cycle while the entry queue has room; each byte
// gives zero to three results, and results leave at one per cycle from
// the output register while rsp_tready is high, so sustained rate is one
// byte per cycle unless the bytes average more than one result. A result
// passes through a queue slot and then the output register before it is
// offered. Reset clears scan state, queue and output valid flag.
// ----------------------------------------------------------------------------
module source_text_lexer_core #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // token_start [15:0], token_length [31:16]
   output logic [6:0]  rsp_tuser,   // token_kind [4:0], error_kind [6:5]
   output logic        rsp_tlast    // last_result
);

   logic               full;
   logic               take;
   logic               push;
   stl_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   stl_pkg::entry_type head_entry;

   assign req_tready = !full;
   assign take       = req_tvalid && !full;

   stl_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push        (push),
      .push_entry  (push_entry)
   );

   stl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   stl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
